@@ src/fep_pkg.sv @@
// Shared constants, types and single-precision arithmetic functions for float_exp_poly.
package fep_pkg;

  localparam logic [31:0] EXP_HI  = 32'h42B0C0A5;
  localparam logic [31:0] EXP_LO  = 32'hC2B0C0A5;
  localparam logic [31:0] LOG2E   = 32'h3FB8AA3B;
  localparam logic [31:0] HALF    = 32'h3F000000;
  localparam logic [31:0] ONE     = 32'h3F800000;
  localparam logic [31:0] LN2_HI  = 32'h3F318000;
  localparam logic [31:0] LN2_LO  = 32'hB95E8083;
  localparam logic [31:0] QNAN    = 32'h7FC00000;
  localparam logic [8:0]  BIAS    = 9'h07F;
  localparam int          POLY_N  = 6;

  typedef struct packed {
    logic [31:0]       r;
    logic signed [8:0] n;
  } red_t;

  // Polynomial coefficients, highest degree first.
  function automatic logic [31:0] coef(input int k);
    case (k)
      0:       return 32'h39506967;
      1:       return 32'h3AB743CE;
      2:       return 32'h3C088908;
      3:       return 32'h3D2AA9C1;
      4:       return 32'h3E2AAAAA;
      5:       return 32'h3F000000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [5:0] lead51(input logic [50:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // Round to nearest even and pack; sig has its leading one at bit 47.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                             input logic [47:0] sig);
    logic [47:0] s;
    logic [47:0] mask;
    logic [5:0]  sh;
    logic [23:0] mant;
    logic        st0, rnd, st, inc;
    logic [30:0] mag;
    logic [7:0]  e8;
    s  = sig;
    e8 = ex[7:0];
    if (sig == '0) return {sgn, 31'b0};
    if (ex >= 12'sd255) return {sgn, 8'hFF, 23'b0};
    if (ex < 12'sd1) begin
      if (ex < -12'sd46) sh = 6'd48;
      else sh = 6'(12'sd1 - ex);
      mask = ~({48{1'b1}} << sh);
      st0  = |(s & mask);
      s    = (s >> sh) | {47'b0, st0};
      e8   = 8'd0;
    end
    mant = s[47:24];
    rnd  = s[23];
    st   = |s[22:0];
    inc  = rnd & (st | mant[0]);
    mag  = {e8, mant[22:0]} + {30'b0, inc};
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic              s, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0]       ma, mb;
    logic signed [11:0] ea, eb, ex;
    logic [47:0]       p, pn;
    logic [5:0]        pos;
    s      = a[31] ^ b[31];
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    if (nan_a || nan_b) return QNAN;
    if (inf_a || inf_b) begin
      if (zero_a || zero_b) return QNAN;
      return {s, 8'hFF, 23'b0};
    end
    if (zero_a || zero_b) return {s, 31'b0};
    ma  = {a[30:23] != '0, a[22:0]};
    mb  = {b[30:23] != '0, b[22:0]};
    ea  = (a[30:23] == '0) ? 12'sd1 : 12'($unsigned(a[30:23]));
    eb  = (b[30:23] == '0) ? 12'sd1 : 12'($unsigned(b[30:23]));
    p   = ma * mb;
    pos = lead51({3'b0, p});
    pn  = p << (6'd47 - pos);
    ex  = ea + eb - 12'sd173 + 12'($unsigned(pos));
    return round_pack(s, ex, pn);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]       x, y;
    logic              nan_a, nan_b, inf_a, inf_b, lost;
    logic [23:0]       mx, my;
    logic signed [11:0] ex, ey, er;
    logic [11:0]       d;
    logic [50:0]       aw, bw, bs, sum, mask;
    logic [5:0]        pos, sh;
    logic [47:0]       sig;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (nan_a || nan_b) return QNAN;
    if (inf_a && inf_b) return (a[31] != b[31]) ? QNAN : a;
    if (inf_a) return a;
    if (inf_b) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    if (x[30:0] == '0) return {x[31] & y[31], 31'b0};
    mx = {x[30:23] != '0, x[22:0]};
    my = {y[30:23] != '0, y[22:0]};
    ex = (x[30:23] == '0) ? 12'sd1 : 12'($unsigned(x[30:23]));
    ey = (y[30:23] == '0) ? 12'sd1 : 12'($unsigned(y[30:23]));
    d  = 12'(ex - ey);
    aw = {1'b0, mx, 26'b0};
    bw = {1'b0, my, 26'b0};
    if (d >= 12'd51) begin
      bs = {50'b0, my != '0};
    end else begin
      mask = ~({51{1'b1}} << d[5:0]);
      bs   = (bw >> d[5:0]) | {50'b0, |(bw & mask)};
    end
    sum = (x[31] == y[31]) ? aw + bs : aw - bs;
    if (sum == '0) return 32'h0;
    pos = lead51(sum);
    er  = ex + 12'($unsigned(pos)) - 12'sd49;
    if (pos >= 6'd47) begin
      sh   = pos - 6'd47;
      mask = ~({51{1'b1}} << sh);
      lost = |(sum & mask);
      sig  = 48'(sum >> sh) | {47'b0, lost};
    end else begin
      sig  = 48'(sum << (6'd47 - pos));
    end
    return round_pack(x[31], er, sig);
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] clamp(input logic [31:0] x);
    logic        nan, lt_hi, gt_lo;
    logic [31:0] a;
    nan   = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    lt_hi = !nan && (x[31] || (x[30:0] < EXP_HI[30:0]));
    a     = lt_hi ? x : EXP_HI;
    gt_lo = !a[31] || (a[30:0] < EXP_LO[30:0]);
    return gt_lo ? a : EXP_LO;
  endfunction

  // Floor of a value known to lie within a few hundred of zero.
  function automatic logic signed [8:0] floor_int(input logic [31:0] b);
    logic [7:0]  e, sh;
    logic [23:0] m, mask, ip;
    logic        fr;
    logic [9:0]  v;
    e = b[30:23];
    m = {1'b1, b[22:0]};
    if (e < 8'd127) begin
      return (b[31] && (b[30:0] != '0)) ? -9'sd1 : 9'sd0;
    end
    sh   = (e >= 8'd150) ? 8'd0 : 8'd150 - e;
    mask = ~({24{1'b1}} << sh);
    ip   = m >> sh;
    fr   = |(m & mask);
    v    = b[31] ? 10'(-(ip + 24'(fr))) : 10'(ip);
    return 9'(v);
  endfunction

  function automatic logic [31:0] int_to_float(input logic signed [8:0] n);
    logic [8:0]  mag;
    logic [5:0]  pos;
    logic [23:0] m;
    if (n == '0) return 32'h0;
    mag = n[8] ? 9'(-n) : 9'(n);
    pos = lead51({42'b0, mag});
    m   = 24'(mag) << (6'd23 - pos);
    return {n[8], 8'(8'd127 + 8'(pos)), m[22:0]};
  endfunction

endpackage

@@ src/fep_reduce.sv @@
// Clamp, integer part of x*log2(e) and two-part range reduction (seven stages).
module fep_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         x,
  output logic                out_valid,
  output fep_pkg::red_t       out
);

  logic [6:0]        v;
  logic [31:0]       a1, a2, a3, a4, a5, m2, b3, t4, hi5, lo5, d6, lo6, r7;
  logic signed [8:0] n4, n5, n6, n7, nf;

  assign nf = fep_pkg::floor_int(b3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= fep_pkg::clamp(x);
      m2  <= fep_pkg::fmul(a1, fep_pkg::LOG2E);
      a2  <= a1;
      b3  <= fep_pkg::fadd(m2, fep_pkg::HALF);
      a3  <= a2;
      n4  <= nf;
      t4  <= fep_pkg::int_to_float(nf);
      a4  <= a3;
      hi5 <= fep_pkg::fmul(t4, fep_pkg::LN2_HI);
      lo5 <= fep_pkg::fmul(t4, fep_pkg::LN2_LO);
      a5  <= a4;
      n5  <= n4;
      d6  <= fep_pkg::fsub(a5, hi5);
      lo6 <= lo5;
      n6  <= n5;
      r7  <= fep_pkg::fsub(d6, lo6);
      n7  <= n6;
    end
  end

  assign out_valid = v[6];
  assign out.r     = r7;
  assign out.n     = n7;

endmodule

@@ src/fep_poly.sv @@
// Horner polynomial and final p*r^2 + r + 1 combination (thirteen stages).
module fep_poly (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  fep_pkg::red_t       in,
  output logic                out_valid,
  output logic [31:0]         sum,
  output logic signed [8:0]   n
);

  localparam int STAGES = 13;

  logic [STAGES-1:0] v;
  logic [31:0]       p  [STAGES];
  logic [31:0]       r  [STAGES-2];
  logic [31:0]       r2 [STAGES-3];
  logic signed [8:0] nq [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= fep_pkg::fmul(fep_pkg::coef(0), in.r);
      r2[0] <= fep_pkg::fmul(in.r, in.r);
      r[0]  <= in.r;
      nq[0] <= in.n;
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        nq[s] <= nq[s-1];
      end
    end

    if (s < STAGES - 2) begin : g_r
      always_ff @(posedge clk) begin
        if (en) begin
          r[s] <= r[s-1];
        end
      end
    end

    if (s < STAGES - 3) begin : g_r2
      always_ff @(posedge clk) begin
        if (en) begin
          r2[s] <= r2[s-1];
        end
      end
    end

    if (s == STAGES - 1) begin : g_one
      always_ff @(posedge clk) begin
        if (en) begin
          p[s] <= fep_pkg::fadd(p[s-1], fep_pkg::ONE);
        end
      end
    end else if (s == STAGES - 2) begin : g_lin
      always_ff @(posedge clk) begin
        if (en) begin
          p[s] <= fep_pkg::fadd(p[s-1], r[s-1]);
        end
      end
    end else if (s == STAGES - 3) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          p[s] <= fep_pkg::fmul(p[s-1], r2[s-1]);
        end
      end
    end else if (s % 2 == 1) begin : g_add
      always_ff @(posedge clk) begin
        if (en) begin
          p[s] <= fep_pkg::fadd(p[s-1], fep_pkg::coef((s + 1) / 2));
        end
      end
    end else begin : g_mul
      always_ff @(posedge clk) begin
        if (en) begin
          p[s] <= fep_pkg::fmul(p[s-1], r[s-1]);
        end
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign sum       = p[STAGES-1];
  assign n         = nq[STAGES-1];

endmodule

@@ src/float_exp_poly.sv @@
// Top level: pipelined single-precision e^x with stream handshakes.
//
// One transaction on the s_ side carries a single-precision operand in
// s_tdata; one transaction on the m_ side carries e^x in m_tdata. Every
// input gives exactly one result, in order.
// The result passes 21 register stages: 7 of clamp and range reduction,
// 13 of polynomial and 1 of scaling by 2^n into the output register.
// Each stage holds at most one float add or up to two independent
// float multiplies.
// Throughput is one transaction per cycle while the output is not stalled; all stages advance together.
// When the receiver holds m_tready low with m_tvalid high, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost
// or repeated, and it resumes as soon as m_tready returns.
// Reset (rst, synchronous) empties the pipeline; s_tready is high the
// cycle after reset is released.
module float_exp_poly (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] x_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] exp_bits
);

  logic              en;
  logic              red_valid, poly_valid;
  fep_pkg::red_t     red;
  logic [31:0]       poly_sum;
  logic signed [8:0] poly_n;
  logic [8:0]        ebias;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  fep_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .x         (s_tdata),
    .out_valid (red_valid),
    .out       (red)
  );

  fep_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (red_valid),
    .in        (red),
    .out_valid (poly_valid),
    .sum       (poly_sum),
    .n         (poly_n)
  );

  assign ebias = 9'(poly_n) + fep_pkg::BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= poly_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= fep_pkg::fmul(poly_sum, {ebias, 23'b0});
    end
  end

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(poly_valid) && $stable(poly_sum)))
    else $error("pipeline moved while output stalled");

  a_no_nan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !((m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != '0)))
    else $error("NaN result");

  a_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("negative result");

  a_n_range: assert property (@(posedge clk) disable iff (rst)
    red_valid |-> ((red.n >= -9'sd127) && (red.n <= 9'sd128)))
    else $error("exponent out of range");

endmodule

@@ tb/tb.sv @@
// Testbench for float_exp_poly: stream e^x checked against an integer-exact float predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] x_bits
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] exp_bits

  logic [31:0] exp_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  float_exp_poly uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // value = sig * 2^lsb_exp, rounded to nearest even
  function automatic logic [31:0] sp_round(input logic sgn, input logic [63:0] sig,
                                           input int lsb_exp);
    logic [127:0] w, mask;
    int           p, lo, sh, be;
    logic [24:0]  m;
    logic         g, st;
    if (sig == '0) return {sgn, 31'b0};
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    lo = p + lsb_exp - 23;
    if (lo < -149) lo = -149;
    sh = lo - lsb_exp;
    w  = 128'(sig);
    if (sh > 0) begin
      if (sh > 100) sh = 100;
      m    = 25'(w >> sh);
      g    = w[sh-1];
      mask = (128'd1 << (sh - 1)) - 1;
      st   = |(w & mask);
    end else begin
      m  = 25'(w << (-sh));
      g  = 1'b0;
      st = 1'b0;
    end
    if (g && (st || m[0])) m = m + 1;
    if (m[24]) begin
      m  = m >> 1;
      lo = lo + 1;
    end
    be = m[23] ? lo + 150 : 0;
    if (be >= 255) return {sgn, 8'hFF, 23'b0};
    return {sgn, 8'(be), m[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == '0);
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    int   ea, eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fep_pkg::QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == '0 || b[30:0] == '0) return fep_pkg::QNAN;
      return {s, 8'hFF, 23'b0};
    end
    if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'b0};
    ea = (a[30:23] == '0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == '0) ? 1 : int'(b[30:23]);
    return sp_round(s, 64'({a[30:23] != '0, a[22:0]}) * 64'({b[30:23] != '0, b[22:0]}),
                    ea + eb - 300);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [63:0] xs, ys, yw, sum;
    int          ex, ey, d;
    if (is_nan(a) || is_nan(b)) return fep_pkg::QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? fep_pkg::QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == '0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == '0) ? 1 : int'(y[30:23]);
    d  = ex - ey;
    xs = 64'({x[30:23] != '0, x[22:0]}) << 30;
    yw = 64'({y[30:23] != '0, y[22:0]}) << 30;
    if (d >= 60) ys = 64'(yw != '0);
    else ys = (yw >> d) | 64'((yw & ((64'd1 << d) - 1)) != '0);
    sum = (x[31] == y[31]) ? xs + ys : xs - ys;
    if (sum == '0) return 32'h0;
    return sp_round(x[31], sum, ex - 180);
  endfunction

  function automatic logic [31:0] ord_key(input logic [31:0] a);
    return a[31] ? ~a : (a | 32'h8000_0000);
  endfunction

  function automatic int floor_of(input logic [31:0] b);
    int          e, sh, ip;
    logic [23:0] m;
    logic        fr;
    e = int'(b[30:23]);
    m = {1'b1, b[22:0]};
    if (e < 127) return (b[31] && b[30:0] != '0) ? -1 : 0;
    sh = (e >= 150) ? 0 : 150 - e;
    ip = int'(m >> sh);
    fr = (m & ((24'd1 << sh) - 1)) != '0;
    return b[31] ? -(ip + int'(fr)) : ip;
  endfunction

  function automatic logic [31:0] exp_of(input logic [31:0] xb);
    logic [31:0] a, b, t, r, r2, p, scale;
    int          n;
    a = (is_nan(xb) || !(ord_key(xb) < ord_key(fep_pkg::EXP_HI))) ? fep_pkg::EXP_HI : xb;
    a = (ord_key(a) > ord_key(fep_pkg::EXP_LO)) ? a : fep_pkg::EXP_LO;
    b = sp_add(sp_mul(a, fep_pkg::LOG2E), fep_pkg::HALF);
    n = floor_of(b);
    t = sp_round(n < 0, 64'((n < 0) ? -n : n), 0);
    // a - t*hi - t*lo
    r  = sp_add(a, sp_mul(t, fep_pkg::LN2_HI) ^ 32'h8000_0000);
    r  = sp_add(r, sp_mul(t, fep_pkg::LN2_LO) ^ 32'h8000_0000);
    r2 = sp_mul(r, r);
    p  = fep_pkg::coef(0);
    for (int k = 1; k < fep_pkg::POLY_N; k++) p = sp_add(sp_mul(p, r), fep_pkg::coef(k));
    p     = sp_add(sp_add(sp_mul(p, r2), r), fep_pkg::ONE);
    scale = 32'(n + 127) << 23;
    return sp_mul(p, scale);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (exp_q.size() == 0) begin
        $error("unexpected transaction exp_bits=%h", m_tdata);
        errors++;
      end else begin
        want = exp_q.pop_front();
        if (m_tdata !== want) begin
          $error("exp_bits expected %h actual %h", want, m_tdata);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [31:0] x);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    exp_q.push_back(exp_of(x));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(3))
      0: return $urandom();
      // mostly in the unclamped range
      default: return {1'(($urandom_range(1))), 8'($urandom_range(133, 90)), 23'($urandom())};
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
             32'h7F80_0001, 32'hFFFF_FFFF, fep_pkg::EXP_HI, fep_pkg::EXP_LO,
             32'h42B0_C0A6, 32'hC2B0_C0A6, 32'h42B0_0000, 32'hC2AF_0000, fep_pkg::ONE,
             32'hBF80_0000, 32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
             fep_pkg::HALF, 32'h3F31_7218, 32'h3380_0000, 32'hBF31_7218, 32'h4120_0000};
    gap_pct = 0;
    stall_pct = 0;
    foreach (vals[i]) send_item(vals[i]);
    wait_drain();
  endtask

  task automatic test_random(input int gap, input int stall, input int count);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_item(rand_operand());
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 200;
    repeat (60) send_item(rand_operand());
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0, 140);
    test_random(70, 0, 140);
    wait_drain();
    test_random(0, 70, 140);
    test_random(34, 34, 140);
    test_backpressure();
    wait_drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
